FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the bottle-line sequencer.
// Each macro expands to one labeled concurrent assertion clocked on aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CFS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cfs: same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cfs: next-cycle assertion failed");

`endif

FILE: sv/cfs_pkg.sv
// Shared types and constants of the bottle-line sequencer.
// No dependencies; used by every other file of the block but assert_macros.svh.
`default_nettype none

package cfs_pkg;

    localparam int CFG_TIME_W  = 20;
    localparam int CFG_SPEED_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;
    localparam int DRIVE_W     = 8;

    // host commands
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_CAM_BLUE = 3'd3;
    localparam logic [2:0] CMD_CAM_RED  = 3'd4;
    localparam logic [2:0] CMD_CAM_NONE = 3'd5;

    // color codes
    localparam logic [2:0] COL_NONE   = 3'd0;
    localparam logic [2:0] COL_RED    = 3'd1;
    localparam logic [2:0] COL_BLUE   = 3'd2;
    localparam logic [2:0] COL_GREEN  = 3'd3;
    localparam logic [2:0] COL_YELLOW = 3'd4;

    // register indexes
    localparam logic [2:0] REG_COOLDOWN     = 3'd0;
    localparam logic [2:0] REG_BLUE_FILL    = 3'd1;
    localparam logic [2:0] REG_RED_FILL     = 3'd2;
    localparam logic [2:0] REG_CAM_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_MAIN_SPEED   = 3'd4;
    localparam logic [2:0] REG_SORTER_SPEED = 3'd5;

    localparam logic [CFG_TIME_W-1:0]  RST_COOLDOWN     = 20'd1000;
    localparam logic [CFG_TIME_W-1:0]  RST_BLUE_FILL    = 20'd3000;
    localparam logic [CFG_TIME_W-1:0]  RST_RED_FILL     = 20'd3000;
    localparam logic [CFG_TIME_W-1:0]  RST_CAM_TIMEOUT  = 20'd5000;
    localparam logic [CFG_SPEED_W-1:0] RST_MAIN_SPEED   = 8'd200;
    localparam logic [CFG_SPEED_W-1:0] RST_SORTER_SPEED = 8'd180;

    // external step numbers
    localparam logic [3:0] CODE_WAIT   = 4'd0;
    localparam logic [3:0] CODE_START  = 4'd1;
    localparam logic [3:0] CODE_DETECT = 4'd2;
    localparam logic [3:0] CODE_EVAL   = 4'd3;
    localparam logic [3:0] CODE_OUTCTL = 4'd4;
    localparam logic [3:0] CODE_ROUTE  = 4'd5;
    localparam logic [3:0] CODE_FBLUE  = 4'd6;
    localparam logic [3:0] CODE_FRED   = 4'd7;
    localparam logic [3:0] CODE_QC     = 4'd8;
    localparam logic [3:0] CODE_QACC   = 4'd9;
    localparam logic [3:0] CODE_IREJ   = 4'd10;
    localparam logic [3:0] CODE_FREJ   = 4'd11;

    typedef enum logic [11:0] {
        ST_WAIT   = 12'h001,
        ST_START  = 12'h002,
        ST_DETECT = 12'h004,
        ST_EVAL   = 12'h008,
        ST_OUTCTL = 12'h010,
        ST_ROUTE  = 12'h020,
        ST_FBLUE  = 12'h040,
        ST_FRED   = 12'h080,
        ST_QC     = 12'h100,
        ST_QACC   = 12'h200,
        ST_IREJ   = 12'h400,
        ST_FREJ   = 12'h800
    } seq_state_t;

    typedef struct packed {
        logic [CFG_TIME_W-1:0]  cooldown;
        logic [CFG_TIME_W-1:0]  blue_fill;
        logic [CFG_TIME_W-1:0]  red_fill;
        logic [CFG_TIME_W-1:0]  cam_timeout;
        logic [CFG_SPEED_W-1:0] main_speed;
        logic [CFG_SPEED_W-1:0] sorter_speed;
    } cfg_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       color_sns;
        logic       bfill_sns;
        logic       rfill_sns;
        logic       cam_sns;
        logic       bexit_sns;
        logic       rexit_sns;
        logic       rej_a_sns;
        logic       rej_b_sns;
        logic [2:0] measured;
    } tick_t;

    typedef struct packed {
        logic reverse;
        logic red_pump;
        logic blue_pump;
        logic final_rej;
        logic primary_rej;
        logic fill_gate;
    } act_t;

    typedef struct packed {
        seq_state_t seq;
        logic [2:0] phys_color;
        logic [2:0] cam_color;
        logic       filling;
        logic       req_pending;
        act_t       act;
    } ctl_t;

    function automatic logic [3:0] state_code(input seq_state_t s);
        logic [3:0] c;
        case (s)
            ST_WAIT:   c = CODE_WAIT;
            ST_START:  c = CODE_START;
            ST_DETECT: c = CODE_DETECT;
            ST_EVAL:   c = CODE_EVAL;
            ST_OUTCTL: c = CODE_OUTCTL;
            ST_ROUTE:  c = CODE_ROUTE;
            ST_FBLUE:  c = CODE_FBLUE;
            ST_FRED:   c = CODE_FRED;
            ST_QC:     c = CODE_QC;
            ST_QACC:   c = CODE_QACC;
            ST_IREJ:   c = CODE_IREJ;
            ST_FREJ:   c = CODE_FREJ;
            default:   c = CODE_WAIT;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cfs_regs.sv
// APB-style configuration register file of the bottle-line sequencer.
// Depends on cfs_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module cfs_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cfs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [cfs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [cfs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output cfs_pkg::cfg_t                        cfg
);
    import cfs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_COOLDOWN:     cfg_next.cooldown     = pwdata[CFG_TIME_W-1:0];
                REG_BLUE_FILL:    cfg_next.blue_fill    = pwdata[CFG_TIME_W-1:0];
                REG_RED_FILL:     cfg_next.red_fill     = pwdata[CFG_TIME_W-1:0];
                REG_CAM_TIMEOUT:  cfg_next.cam_timeout  = pwdata[CFG_TIME_W-1:0];
                REG_MAIN_SPEED:   cfg_next.main_speed   = pwdata[CFG_SPEED_W-1:0];
                REG_SORTER_SPEED: cfg_next.sorter_speed = pwdata[CFG_SPEED_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_COOLDOWN:     prdata = CFG_DATA_W'(cfg_reg.cooldown);
            REG_BLUE_FILL:    prdata = CFG_DATA_W'(cfg_reg.blue_fill);
            REG_RED_FILL:     prdata = CFG_DATA_W'(cfg_reg.red_fill);
            REG_CAM_TIMEOUT:  prdata = CFG_DATA_W'(cfg_reg.cam_timeout);
            REG_MAIN_SPEED:   prdata = CFG_DATA_W'(cfg_reg.main_speed);
            REG_SORTER_SPEED: prdata = CFG_DATA_W'(cfg_reg.sorter_speed);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cooldown     <= RST_COOLDOWN;
            cfg_reg.blue_fill    <= RST_BLUE_FILL;
            cfg_reg.red_fill     <= RST_RED_FILL;
            cfg_reg.cam_timeout  <= RST_CAM_TIMEOUT;
            cfg_reg.main_speed   <= RST_MAIN_SPEED;
            cfg_reg.sorter_speed <= RST_SORTER_SPEED;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cfs_step.sv
// Next-state logic for one 1 ms tick of the bottle-line sequencer.
// Purely combinational; depends on cfs_pkg for the state and config types.
`default_nettype none

module cfs_step #(
    parameter int TIMER_BITS = 20,
    parameter int SPEED_BITS = 8
) (
    input  wire cfs_pkg::cfg_t     cfg,
    input  wire cfs_pkg::tick_t    tick,
    input  wire cfs_pkg::ctl_t     ctl_cur,
    input  wire logic [TIMER_BITS-1:0]  since_cur,
    input  wire logic [TIMER_BITS-1:0]  ist_cur,
    input  wire logic [SPEED_BITS-1:0]  main_cur,
    input  wire logic [SPEED_BITS-1:0]  sorter_cur,
    output cfs_pkg::ctl_t          ctl_next,
    output logic [TIMER_BITS-1:0]  since_next,
    output logic [TIMER_BITS-1:0]  ist_next,
    output logic [SPEED_BITS-1:0]  main_next,
    output logic [SPEED_BITS-1:0]  sorter_next,
    output logic                   cam_req_next
);
    import cfs_pkg::*;

    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic [SPEED_BITS+CFG_SPEED_W-1:0] mrun_ext;
    logic [SPEED_BITS+CFG_SPEED_W-1:0] srun_ext;
    logic [SPEED_BITS-1:0]             mrun;
    logic [SPEED_BITS-1:0]             srun;
    logic                              reject_hit;
    logic                              cam_blue;

    assign mrun_ext   = {SPEED_BITS'(0), cfg.main_speed};
    assign srun_ext   = {SPEED_BITS'(0), cfg.sorter_speed};
    assign mrun       = mrun_ext[SPEED_BITS-1:0];
    assign srun       = srun_ext[SPEED_BITS-1:0];
    assign reject_hit = tick.rej_a_sns || tick.rej_b_sns;
    // camera color is not changed in quality accepted itself, so the current one serves
    assign cam_blue   = (ctl_cur.cam_color == COL_BLUE);

    // timer >= limit, compared at the sum of the two widths
    function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                     input logic [CFG_TIME_W-1:0] lim);
        logic [TIMER_BITS+CFG_TIME_W-1:0] a;
        logic [TIMER_BITS+CFG_TIME_W-1:0] b;
        a = {CFG_TIME_W'(0), t};
        b = {TIMER_BITS'(0), lim};
        return a >= b;
    endfunction

    always_comb begin
        ctl_next     = ctl_cur;
        main_next    = main_cur;
        sorter_next  = sorter_cur;
        cam_req_next = 1'b0;
        since_next   = (since_cur == TMAX) ? since_cur : since_cur + 1'b1;
        ist_next     = (ist_cur == TMAX) ? ist_cur : ist_cur + 1'b1;

        if (tick.cmd == CMD_STOP) begin
            ctl_next.seq         = ST_WAIT;
            ctl_next.phys_color  = COL_NONE;
            ctl_next.cam_color   = COL_NONE;
            ctl_next.filling     = 1'b0;
            ctl_next.req_pending = 1'b0;
            ctl_next.act         = '0;
            since_next           = '0;
            ist_next             = '0;
            main_next            = '0;
            sorter_next          = '0;
        end

        case (ctl_next.seq)
            ST_WAIT: begin
                if (tick.cmd == CMD_START) begin
                    ctl_next.seq = ST_START;
                    ist_next     = '0;
                end
            end
            ST_START: begin
                ctl_next.act.fill_gate   = 1'b0;
                ctl_next.act.primary_rej = 1'b0;
                ctl_next.act.final_rej   = 1'b0;
                sorter_next              = '0;
                main_next                = mrun;
                ctl_next.seq             = ST_DETECT;
                ist_next                 = '0;
            end
            ST_DETECT: begin
                if (tick.color_sns && reached(since_next, cfg.cooldown)) begin
                    since_next   = '0;
                    main_next    = '0;
                    ctl_next.seq = ST_EVAL;
                    ist_next     = '0;
                end
            end
            ST_EVAL: begin
                ctl_next.phys_color = (tick.measured <= COL_YELLOW) ? tick.measured
                                                                     : COL_NONE;
                ctl_next.seq        = ST_OUTCTL;
                ist_next            = '0;
            end
            ST_OUTCTL: begin
                main_next = mrun;
                ist_next  = '0;
                if (ctl_next.phys_color == COL_RED || ctl_next.phys_color == COL_BLUE) begin
                    ctl_next.act.fill_gate = 1'b1;
                    ctl_next.seq           = ST_ROUTE;
                end else begin
                    ctl_next.act.primary_rej = 1'b1;
                    ctl_next.seq             = ST_IREJ;
                end
            end
            ST_ROUTE: begin
                ist_next = '0;
                if (ctl_next.phys_color == COL_BLUE) begin
                    ctl_next.seq     = ST_FBLUE;
                    ctl_next.filling = 1'b0;
                end else if (ctl_next.phys_color == COL_RED) begin
                    ctl_next.seq     = ST_FRED;
                    ctl_next.filling = 1'b0;
                end else begin
                    ctl_next.seq = ST_IREJ;
                end
            end
            ST_FBLUE: begin
                if (!ctl_next.filling && tick.bfill_sns) begin
                    main_next              = '0;
                    ctl_next.act.fill_gate = 1'b0;
                    ctl_next.act.blue_pump = 1'b1;
                    ctl_next.filling       = 1'b1;
                    ist_next               = '0;
                end
                if (ctl_next.filling && reached(ist_next, cfg.blue_fill)) begin
                    ctl_next.act.blue_pump = 1'b0;
                    main_next              = mrun;
                    ctl_next.filling       = 1'b0;
                    ctl_next.seq           = ST_QC;
                    ist_next               = '0;
                    ctl_next.req_pending   = 1'b0;
                    ctl_next.cam_color     = COL_NONE;
                end
            end
            ST_FRED: begin
                if (!ctl_next.filling && tick.rfill_sns) begin
                    main_next              = '0;
                    ctl_next.act.fill_gate = 1'b0;
                    ctl_next.act.red_pump  = 1'b1;
                    ctl_next.filling       = 1'b1;
                    ist_next               = '0;
                end
                if (ctl_next.filling && reached(ist_next, cfg.red_fill)) begin
                    ctl_next.act.red_pump = 1'b0;
                    main_next             = mrun;
                    ctl_next.filling      = 1'b0;
                    ctl_next.seq          = ST_QC;
                    ist_next              = '0;
                    ctl_next.req_pending  = 1'b0;
                    ctl_next.cam_color    = COL_NONE;
                end
            end
            ST_QC: begin
                if (!ctl_next.req_pending && tick.cam_sns) begin
                    main_next            = '0;
                    cam_req_next         = 1'b1;
                    ctl_next.req_pending = 1'b1;
                    ist_next             = '0;
                end
                if (ctl_next.req_pending) begin
                    if (tick.cmd == CMD_CAM_BLUE || tick.cmd == CMD_CAM_RED) begin
                        ctl_next.cam_color = (tick.cmd == CMD_CAM_BLUE) ? COL_BLUE
                                                                        : COL_RED;
                        main_next          = mrun;
                        ctl_next.seq       = ST_QACC;
                        ist_next           = '0;
                    end else if (tick.cmd == CMD_CAM_NONE) begin
                        ctl_next.cam_color = COL_NONE;
                        main_next          = mrun;
                        ctl_next.seq       = ST_FREJ;
                        ist_next           = '0;
                    end
                    if (ctl_next.seq == ST_QC && reached(ist_next, cfg.cam_timeout)) begin
                        ctl_next.req_pending = 1'b0;
                    end
                end
            end
            ST_QACC: begin
                if (ctl_next.cam_color == COL_BLUE || ctl_next.cam_color == COL_RED) begin
                    sorter_next          = srun;
                    ctl_next.act.reverse = !cam_blue;
                    if (cam_blue ? tick.bexit_sns : tick.rexit_sns) begin
                        sorter_next  = '0;
                        ctl_next.seq = ST_START;
                        ist_next     = '0;
                    end
                end else begin
                    ctl_next.seq = ST_FREJ;
                    ist_next     = '0;
                end
            end
            ST_IREJ: begin
                if (reject_hit) begin
                    ctl_next.act.primary_rej = 1'b0;
                    main_next                = '0;
                    ctl_next.seq             = ST_START;
                    ist_next                 = '0;
                end
            end
            ST_FREJ: begin
                ctl_next.act.final_rej = 1'b1;
                ctl_next.act.reverse   = 1'b1;
                sorter_next            = srun;
                if (reject_hit) begin
                    sorter_next            = '0;
                    ctl_next.act.final_rej = 1'b0;
                    ctl_next.seq           = ST_START;
                    ist_next               = '0;
                end
            end
            default: begin
                ctl_next.seq = ST_WAIT;
                ist_next     = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/conveyor_fill_sort_sequencer_top.sv
// Top level of the bottle-line sequencer: beat registers, handshakes, state.
// Depends on cfs_pkg, cfs_regs and cfs_step.
//
// Usage notes:
//  - s_ channel: one beat per 1 ms tick (host command, eight station sensors,
//    measured color). m_ channel: one beat per tick, the state after it.
//  - APB port sets cooldown, fill times, camera timeout and drive levels.
//    Write only while no tick is in flight.
//  - A beat accepted on s_ is held in the input register; its result is
//    computed in one step into the state/result registers and shown on m_.
//  - Throughput: one beat per cycle while m_tready stays high, set by the
//    single step from input register to the state/result registers.
//  - The sequence state, timers, drive levels and actuators are themselves
//    the result register; they only advance when the result slot is free or draining.
//  - Receiver stall: the result holds, one more beat waits in the input
//    register, then s_tready drops until m_tready returns.
//  - Reset (aresetn low, synchronous): both channels empty, sequence in
//    waiting start, everything stopped, registers back to defaults.
//  - The STOP command clears the sequence state but not the registers.
`default_nettype none

module conveyor_fill_sort_sequencer_top #(
    parameter int TIMER_BITS = 20,
    parameter int SPEED_BITS = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata from bit 0: command[2:0], color_station_sensor, blue_fill_sensor,
    // red_fill_sensor, camera_station_sensor, blue_exit_sensor, red_exit_sensor,
    // reject_sensor_a, reject_sensor_b, measured_color[2:0], zero pad
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [cfs_pkg::IN_DATA_W-1:0]   s_tdata,
    // m_tdata from bit 0: sequence_state[3:0], main_drive[7:0],
    // sorter_drive[7:0], sorter_reverse, filling_gate_open, primary_reject_open,
    // final_reject_open, blue_pump_on, red_pump_on, camera_request,
    // bottle_color[2:0], zero pad
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [cfs_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cfs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [cfs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [cfs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import cfs_pkg::*;

    cfg_t                  cfg;

    // input beat register
    logic                  in_vld_reg;
    logic                  in_vld_next;
    tick_t                 tick_reg;
    tick_t                 tick_in;

    // state / result register
    logic                  out_vld_reg;
    logic                  out_vld_next;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [TIMER_BITS-1:0] since_reg;
    logic [TIMER_BITS-1:0] since_next;
    logic [TIMER_BITS-1:0] ist_reg;
    logic [TIMER_BITS-1:0] ist_next;
    logic [SPEED_BITS-1:0] main_reg;
    logic [SPEED_BITS-1:0] main_next;
    logic [SPEED_BITS-1:0] sorter_reg;
    logic [SPEED_BITS-1:0] sorter_next;
    logic                  cam_req_reg;
    logic                  cam_req_next;

    logic                  s_fire;
    logic                  advance;
    logic [SPEED_BITS+DRIVE_W-1:0] main_ext;
    logic [SPEED_BITS+DRIVE_W-1:0] sorter_ext;

    cfs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfs_step #(
        .TIMER_BITS (TIMER_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_step (
        .cfg          (cfg),
        .tick         (tick_reg),
        .ctl_cur      (ctl_reg),
        .since_cur    (since_reg),
        .ist_cur      (ist_reg),
        .main_cur     (main_reg),
        .sorter_cur   (sorter_reg),
        .ctl_next     (ctl_next),
        .since_next   (since_next),
        .ist_next     (ist_next),
        .main_next    (main_next),
        .sorter_next  (sorter_next),
        .cam_req_next (cam_req_next)
    );

    // unpack input beat
    assign tick_in.cmd       = s_tdata[2:0];
    assign tick_in.color_sns = s_tdata[3];
    assign tick_in.bfill_sns = s_tdata[4];
    assign tick_in.rfill_sns = s_tdata[5];
    assign tick_in.cam_sns   = s_tdata[6];
    assign tick_in.bexit_sns = s_tdata[7];
    assign tick_in.rexit_sns = s_tdata[8];
    assign tick_in.rej_a_sns = s_tdata[9];
    assign tick_in.rej_b_sns = s_tdata[10];
    assign tick_in.measured  = s_tdata[13:11];

    // the step fires when a tick waits and the result slot is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            tick_reg <= tick_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg          <= 1'b0;
            out_vld_reg         <= 1'b0;
            ctl_reg.seq         <= ST_WAIT;
            ctl_reg.phys_color  <= COL_NONE;
            ctl_reg.cam_color   <= COL_NONE;
            ctl_reg.filling     <= 1'b0;
            ctl_reg.req_pending <= 1'b0;
            ctl_reg.act         <= '0;
            since_reg           <= '0;
            ist_reg             <= '0;
            main_reg            <= '0;
            sorter_reg          <= '0;
            cam_req_reg         <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                ctl_reg     <= ctl_next;
                since_reg   <= since_next;
                ist_reg     <= ist_next;
                main_reg    <= main_next;
                sorter_reg  <= sorter_next;
                cam_req_reg <= cam_req_next;
            end
        end
    end

    // drive levels onto the fixed 8-bit fields
    assign main_ext   = {DRIVE_W'(0), main_reg};
    assign sorter_ext = {DRIVE_W'(0), sorter_reg};

    assign m_tvalid       = out_vld_reg;
    assign m_tdata[3:0]   = state_code(ctl_reg.seq);
    assign m_tdata[11:4]  = main_ext[DRIVE_W-1:0];
    assign m_tdata[19:12] = sorter_ext[DRIVE_W-1:0];
    assign m_tdata[20]    = ctl_reg.act.reverse;
    assign m_tdata[21]    = ctl_reg.act.fill_gate;
    assign m_tdata[22]    = ctl_reg.act.primary_rej;
    assign m_tdata[23]    = ctl_reg.act.final_rej;
    assign m_tdata[24]    = ctl_reg.act.blue_pump;
    assign m_tdata[25]    = ctl_reg.act.red_pump;
    assign m_tdata[26]    = cam_req_reg;
    assign m_tdata[29:27] = ctl_reg.phys_color;
    assign m_tdata[31:30] = '0;

endmodule

`default_nettype wire

FILE: sv/cfs_checker.sv
// Port-level checker for the bottle-line sequencer, bound to the top level.
// Depends on cfs_pkg for step codes and on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cfs_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [cfs_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import cfs_pkg::*;

    // stalled result beat holds its payload
    `CFS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata))
    // camera is only asked in quality control; an answer on the same tick moves on at once
    `CFS_ASSERT_SAME(a_cam_in_qc, m_tvalid && m_tdata[26], m_tdata[3:0] == CODE_QC || m_tdata[3:0] == CODE_QACC || m_tdata[3:0] == CODE_FREJ)
    // blue pump only runs in the blue fill step, red pump in the red one
    `CFS_ASSERT_SAME(a_blue_pump, m_tvalid && m_tdata[24], m_tdata[3:0] == CODE_FBLUE)
    `CFS_ASSERT_SAME(a_red_pump, m_tvalid && m_tdata[25], m_tdata[3:0] == CODE_FRED)
    // final reject gate open only during final reject
    `CFS_ASSERT_SAME(a_final_gate, m_tvalid && m_tdata[23], m_tdata[3:0] == CODE_FREJ)

endmodule

bind conveyor_fill_sort_sequencer_top cfs_checker u_cfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
